// ===== sv/teq_pkg.sv =====
// Package for the timer event queue: opcodes, status codes, states, shared types.
// No dependencies.
`timescale 1ns / 1ps
package teq_pkg;

  localparam int unsigned QueueDepthDef = 16;

  typedef enum logic [2:0] {
    OP_ADD    = 3'd0,
    OP_DELETE = 3'd1,
    OP_RUN    = 3'd2,
    OP_FINISH = 3'd3,
    OP_WAIT   = 3'd4
  } op_e;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_ERR   = 2'd1,
    ST_EMPTY = 2'd2,
    ST_NDUE  = 2'd3
  } status_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_FIND,
    S_SHIFT_UP,
    S_SHIFT_DN,
    S_OUT
  } state_e;

  // controller -> datapath commands
  typedef struct packed {
    logic load;       // capture request
    logic scan_start; // clear scan index
    logic scan_step;  // advance scan index
    logic up_start;   // begin insert shifting from the tail
    logic up_step;    // move one entry up
    logic up_done;    // write new entry at the found slot
    logic dn_step;    // move one entry down
    logic pop;        // take the head as the fired entry before it is shifted out
    logic finish;     // apply counters and fired state, build result
  } cmd_t;

  // datapath -> controller status
  typedef struct packed {
    logic [2:0] op;
    logic       scan_end;  // scan index reached count
    logic       scan_hit;  // entry at scan index matches
    logic       up_end;    // shift pointer reached found slot
    logic       dn_end;    // shift pointer reached last entry
    logic       full;
    logic       ins_ok;    // insert is permitted
    logic       head_due;
    logic       fired;
    logic       empty;
  } stat_t;

endpackage

// ===== sv/teq_ctrl.sv =====
// Controller for the timer event queue: sequences scans and shifts.
// Depends on teq_pkg.
`timescale 1ns / 1ps
module teq_ctrl import teq_pkg::*; (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  in_fire_i,
  input  logic  out_taken_i,
  input  stat_t stat_i,
  output cmd_t  cmd_o,
  output logic  busy_o,
  output logic  out_valid_o
);

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) state_q <= S_IDLE;
    else state_q <= state_d;
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: if (in_fire_i) state_d = S_FIND;
      S_FIND: begin
        case (stat_i.op)
          OP_ADD, OP_FINISH: begin
            if (!stat_i.ins_ok) state_d = S_OUT;
            else if (stat_i.scan_end || stat_i.scan_hit) state_d = S_SHIFT_UP;
          end
          OP_DELETE: begin
            if (stat_i.scan_end) state_d = S_OUT;
            else if (stat_i.scan_hit) state_d = S_SHIFT_DN;
          end
          OP_RUN: begin
            if (!stat_i.fired && !stat_i.empty && stat_i.head_due) state_d = S_SHIFT_DN;
            else state_d = S_OUT;
          end
          default: state_d = S_OUT;
        endcase
      end
      S_SHIFT_UP: if (stat_i.up_end) state_d = S_OUT;
      S_SHIFT_DN: if (stat_i.dn_end) state_d = S_OUT;
      S_OUT: if (out_taken_i) state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  always_comb begin
    cmd_o = '0;
    case (state_q)
      S_IDLE: begin
        cmd_o.load       = in_fire_i;
        cmd_o.scan_start = in_fire_i;
      end
      S_FIND: begin
        case (stat_i.op)
          OP_ADD, OP_FINISH: begin
            if (!stat_i.ins_ok) cmd_o.finish = 1'b1;
            else if (stat_i.scan_end || stat_i.scan_hit) cmd_o.up_start = 1'b1;
            else cmd_o.scan_step = 1'b1;
          end
          OP_DELETE: begin
            if (stat_i.scan_end) cmd_o.finish = 1'b1;
            else if (!stat_i.scan_hit) cmd_o.scan_step = 1'b1;
          end
          OP_RUN: begin
            if (!stat_i.fired && !stat_i.empty && stat_i.head_due) cmd_o.pop = 1'b1;
            else cmd_o.finish = 1'b1;
          end
          default: cmd_o.finish = 1'b1;
        endcase
      end
      S_SHIFT_UP: begin
        if (stat_i.up_end) begin
          cmd_o.up_done = 1'b1;
          cmd_o.finish  = 1'b1;
        end else cmd_o.up_step = 1'b1;
      end
      S_SHIFT_DN: begin
        if (stat_i.dn_end) cmd_o.finish = 1'b1;
        else cmd_o.dn_step = 1'b1;
      end
      default: ;
    endcase
  end

  assign busy_o      = (state_q != S_IDLE);
  assign out_valid_o = (state_q == S_OUT);

endmodule

// ===== sv/teq_datapath.sv =====
// Datapath for the timer event queue: entry memory, scan pointer, fired slot.
// Depends on teq_pkg.
`timescale 1ns / 1ps
module teq_datapath import teq_pkg::*; #(
  parameter int unsigned QueueDepth = QueueDepthDef
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  cmd_t        cmd_i,
  input  logic [2:0]  op_i,
  input  logic [31:0] now_i,
  input  logic [23:0] iv_i,
  input  logic [30:0] id_i,
  input  logic        keep_i,
  output stat_t       stat_o,
  output logic [1:0]  status_o,
  output logic [30:0] rid_o,
  output logic [30:0] wait_o,
  output logic [8:0]  pending_o
);

  localparam int unsigned IdxW = (QueueDepth > 1) ? $clog2(QueueDepth) : 1;
  localparam int unsigned CntW = $clog2(QueueDepth + 1);

  // entries kept as registers: shifting touches neighbors at the moving pointer
  logic [31:0] exp_q [QueueDepth];
  logic [23:0] ivl_q [QueueDepth];
  logic [30:0] idn_q [QueueDepth];

  logic [CntW-1:0] cnt_q, cnt_d;
  logic [30:0]     next_q, next_d;
  logic            fv_q, fv_d;
  logic [30:0]     fid_q, fid_d;
  logic [23:0]     fiv_q, fiv_d;
  logic            popped_q, popped_d;  // run took the head this request

  logic [2:0]  op_q;
  logic [31:0] now_q;
  logic [23:0] iv_q;
  logic [30:0] id_q;
  logic        keep_q;
  logic [CntW-1:0] pos_q;   // scan index, then slot of insert/delete
  logic [CntW-1:0] ptr_q;   // shift pointer

  logic [1:0]  status_q, status_d;
  logic [30:0] rid_q, rid_d, wait_q, wait_d;

  // fields of the request being inserted
  logic [31:0] ins_exp;
  logic [23:0] ins_iv;
  logic [30:0] ins_id;
  logic        is_add;
  logic [31:0] diff_s, diff_h;
  logic [IdxW-1:0] pos_ix, ptr_ix, ptrm_ix, ptrp_ix;
  logic        full;

  assign is_add  = (op_q == OP_ADD);
  assign ins_iv  = is_add ? iv_q : fiv_q;
  assign ins_exp = now_q + {8'd0, ins_iv};
  assign ins_id  = is_add ? next_q : fid_q;
  assign pos_ix  = pos_q[IdxW-1:0];
  assign ptr_ix  = ptr_q[IdxW-1:0];
  assign ptrm_ix = ptr_ix - IdxW'(1);
  assign ptrp_ix = ptr_ix + IdxW'(1);
  assign full    = (cnt_q >= CntW'(QueueDepth));
  assign diff_s  = ins_exp - exp_q[pos_ix];
  assign diff_h  = exp_q[0] - now_q;

  always_comb begin
    stat_o          = '0;
    stat_o.op       = op_q;
    stat_o.scan_end = (pos_q >= cnt_q);
    stat_o.scan_hit = (op_q == OP_DELETE) ? (idn_q[pos_ix] == id_q) : diff_s[31];
    stat_o.up_end   = (ptr_q == pos_q);
    stat_o.dn_end   = (ptr_q + CntW'(1) >= cnt_q);
    stat_o.full     = full;
    stat_o.ins_ok   = is_add ? (iv_q != 24'd0 && !full) : (fv_q && keep_q && !full);
    stat_o.head_due = (diff_h == 32'd0) || diff_h[31];
    stat_o.fired    = fv_q;
    stat_o.empty    = (cnt_q == '0);
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      op_q <= op_i; now_q <= now_i; iv_q <= iv_i; id_q <= id_i; keep_q <= keep_i;
    end
    if (cmd_i.scan_start) pos_q <= '0;
    else if (cmd_i.scan_step) pos_q <= pos_q + CntW'(1);
    if (cmd_i.up_start) ptr_q <= cnt_q;
    else if (cmd_i.up_step) ptr_q <= ptr_q - CntW'(1);
    else if (cmd_i.dn_step) ptr_q <= ptr_q + CntW'(1);
    else if (cmd_i.scan_start) ptr_q <= '0;
    else if (cmd_i.scan_step) ptr_q <= pos_q + CntW'(1);
    if (cmd_i.up_step) begin
      exp_q[ptr_ix] <= exp_q[ptrm_ix];
      ivl_q[ptr_ix] <= ivl_q[ptrm_ix];
      idn_q[ptr_ix] <= idn_q[ptrm_ix];
    end
    if (cmd_i.up_done) begin
      exp_q[pos_ix] <= ins_exp;
      ivl_q[pos_ix] <= ins_iv;
      idn_q[pos_ix] <= ins_id;
    end
    if (cmd_i.dn_step) begin
      exp_q[ptr_ix] <= exp_q[ptrp_ix];
      ivl_q[ptr_ix] <= ivl_q[ptrp_ix];
      idn_q[ptr_ix] <= idn_q[ptrp_ix];
    end
  end

  always_comb begin
    cnt_d    = cnt_q;
    next_d   = next_q;
    fv_d     = fv_q;
    fid_d    = fid_q;
    fiv_d    = fiv_q;
    popped_d = popped_q;
    status_d = status_q;
    rid_d    = rid_q;
    wait_d   = wait_q;
    if (cmd_i.load) popped_d = 1'b0;
    // head is captured before the down-shift overwrites slot zero
    if (cmd_i.pop) begin
      popped_d = 1'b1; fv_d = 1'b1; fid_d = idn_q[0]; fiv_d = ivl_q[0];
    end
    if (cmd_i.finish) begin
      status_d = ST_ERR; rid_d = '0; wait_d = '0;
      case (op_q)
        OP_ADD: if (cmd_i.up_done) begin
          cnt_d = cnt_q + CntW'(1);
          rid_d = next_q;
          next_d = (next_q == 31'h7FFF_FFFF) ? 31'd1 : next_q + 31'd1;
          status_d = ST_OK;
        end
        OP_DELETE: if (pos_q < cnt_q) begin
          cnt_d = cnt_q - CntW'(1); rid_d = id_q; status_d = ST_OK;
        end
        OP_RUN: begin
          if (popped_q) begin
            cnt_d = cnt_q - CntW'(1); rid_d = fid_q; status_d = ST_OK;
          end else if (fv_q) status_d = ST_ERR;
          else if (cnt_q == '0) status_d = ST_EMPTY;
          else status_d = ST_NDUE;
        end
        OP_FINISH: if (fv_q) begin
          fv_d = 1'b0; rid_d = fid_q;
          if (!keep_q) status_d = ST_OK;
          else if (cmd_i.up_done) begin
            cnt_d = cnt_q + CntW'(1); status_d = ST_OK;
          end
        end
        OP_WAIT: begin
          if (cnt_q == '0) status_d = ST_EMPTY;
          else begin
            status_d = ST_OK;
            wait_d = diff_h[31] ? 31'd0 : diff_h[30:0];
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0; next_q <= 31'd1; fv_q <= 1'b0; fid_q <= '0; fiv_q <= '0;
      popped_q <= 1'b0; status_q <= ST_ERR; rid_q <= '0; wait_q <= '0;
    end else begin
      cnt_q <= cnt_d; next_q <= next_d; fv_q <= fv_d; fid_q <= fid_d; fiv_q <= fiv_d;
      popped_q <= popped_d; status_q <= status_d; rid_q <= rid_d; wait_q <= wait_d;
    end
  end

  // run pops through the down-shift starting at slot zero
  assign status_o  = status_q;
  assign rid_o     = rid_q;
  assign wait_o    = wait_q;
  assign pending_o = 9'(cnt_q);

endmodule

// ===== sv/timer_event_queue.sv =====
// Top level of the timer event queue: request stream in, result stream out.
// Depends on teq_pkg, teq_ctrl, teq_datapath.
//
//  channel | dir | tdata fields (low bit up)                          | tuser
//  s_axis  | in  | opcode, now_ms, interval_ms, event_id, keep (91b)  | -
//  m_axis  | out | status, result_id, wait_ms, pending (73b)           | -
//
// One request at a time: from accept to result the controller finds the slot, shifts
// entries one at a time where the request needs it (scan and shift together cover the
// queued entries once), then holds the result in the output state.
// A taken result returns the controller to idle; only there is a request accepted.
// Reset clears the count, ids and fired slot; entry storage is not cleared.
// A result holds on m_axis until taken; s_axis_tready stays low until then.
`timescale 1ns / 1ps
module timer_event_queue import teq_pkg::*; #(
  parameter int unsigned QueueDepth = QueueDepthDef
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  input  logic [95:0]  s_axis_tdata,  // opcode, now_ms, interval_ms, event_id, keep
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  output logic [79:0]  m_axis_tdata   // status, result_id, wait_ms, pending
);

  cmd_t  cmd;
  stat_t stat;
  logic  busy, in_fire;
  logic [1:0]  status;
  logic [30:0] rid, wait_ms;
  logic [8:0]  pending;

  assign s_axis_tready = !busy;
  assign in_fire = s_axis_tvalid && s_axis_tready;

  teq_ctrl u_ctrl (
    .clk_i, .rst_ni, .in_fire_i(in_fire), .out_taken_i(m_axis_tready),
    .stat_i(stat), .cmd_o(cmd), .busy_o(busy), .out_valid_o(m_axis_tvalid)
  );

  teq_datapath #(.QueueDepth(QueueDepth)) u_dp (
    .clk_i, .rst_ni, .cmd_i(cmd),
    .op_i(s_axis_tdata[2:0]), .now_i(s_axis_tdata[34:3]),
    .iv_i(s_axis_tdata[58:35]), .id_i(s_axis_tdata[89:59]), .keep_i(s_axis_tdata[90]),
    .stat_o(stat), .status_o(status), .rid_o(rid), .wait_o(wait_ms), .pending_o(pending)
  );

  assign m_axis_tdata = {7'd0, pending, wait_ms, rid, status};

endmodule

// ===== verif/timer_event_queue_tb.sv =====
// Testbench for timer_event_queue: directed and random timer requests, with results
// checked against a behavioral copy of the sorted queue. Depends on teq_pkg and the RTL.
`timescale 1ns / 1ps
module timer_event_queue_tb;
  import teq_pkg::*;

  localparam int Depth = 16;

  // packed from the top bit down: status lands in the lowest bits
  typedef struct packed {
    logic [8:0]  pending;
    logic [30:0] wait_ms;
    logic [30:0] rid;
    logic [1:0]  status;
  } result_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [95:0] s_axis_tdata = '0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [79:0] m_axis_tdata;

  timer_event_queue dut (.*);

  always #5 clk_i = ~clk_i;

  // behavioral copy of the queue state
  logic [31:0] q_exp [Depth];
  logic [23:0] q_iv  [Depth];
  logic [30:0] q_id  [Depth];
  int          q_cnt;
  logic [30:0] nxt_id;
  bit          fired_v;
  logic [30:0] fired_id;
  logic [23:0] fired_iv;

  result_t expected_q[$];
  int      mismatches = 0;
  int      results_seen = 0;
  int      sent = 0;
  bit      quiet = 1'b0;   // no-idle stretch
  bit      hold_off = 1'b0;
  logic [31:0] clock_ms = 32'd1000;
  int      op_hits[8];

  function automatic bit is_earlier(logic [31:0] a, logic [31:0] b);
    logic [31:0] d;
    d = a - b;
    return d[31];
  endfunction

  function automatic bit queue_insert(logic [31:0] e, logic [23:0] iv, logic [30:0] id);
    int pos;
    if (q_cnt >= Depth) return 1'b0;
    pos = q_cnt;
    for (int i = 0; i < q_cnt; i++)
      if (is_earlier(e, q_exp[i])) begin
        pos = i;
        break;
      end
    for (int i = q_cnt; i > pos; i--) begin
      q_exp[i] = q_exp[i-1];
      q_iv[i]  = q_iv[i-1];
      q_id[i]  = q_id[i-1];
    end
    q_exp[pos] = e;
    q_iv[pos]  = iv;
    q_id[pos]  = id;
    q_cnt++;
    return 1'b1;
  endfunction

  function automatic void queue_remove(int pos);
    for (int i = pos; i + 1 < q_cnt; i++) begin
      q_exp[i] = q_exp[i+1];
      q_iv[i]  = q_iv[i+1];
      q_id[i]  = q_id[i+1];
    end
    q_cnt--;
  endfunction

  function automatic result_t apply_request(logic [2:0] op, logic [31:0] now,
                                            logic [23:0] iv, logic [30:0] id, bit keep);
    result_t r;
    logic [31:0] d;
    r = '0;
    r.status = ST_ERR;
    case (op)
      OP_ADD: begin
        if (iv != 0 && queue_insert(now + iv, iv, nxt_id)) begin
          r.rid = nxt_id;
          nxt_id = (nxt_id == 31'h7FFFFFFF) ? 31'd1 : nxt_id + 31'd1;
          r.status = ST_OK;
        end
      end
      OP_DELETE: begin
        for (int i = 0; i < q_cnt; i++)
          if (q_id[i] == id) begin
            queue_remove(i);
            r.rid = id;
            r.status = ST_OK;
            break;
          end
      end
      OP_RUN: begin
        if (fired_v) r.status = ST_ERR;
        else if (q_cnt == 0) r.status = ST_EMPTY;
        else begin
          d = q_exp[0] - now;
          if (d == 0 || d[31]) begin
            fired_v = 1'b1;
            fired_id = q_id[0];
            fired_iv = q_iv[0];
            queue_remove(0);
            r.rid = fired_id;
            r.status = ST_OK;
          end else begin
            r.status = ST_NDUE;
          end
        end
      end
      OP_FINISH: begin
        if (fired_v) begin
          fired_v = 1'b0;
          r.rid = fired_id;
          if (keep) r.status = queue_insert(now + fired_iv, fired_iv, fired_id) ? ST_OK : ST_ERR;
          else r.status = ST_OK;
        end
      end
      OP_WAIT: begin
        if (q_cnt == 0) r.status = ST_EMPTY;
        else begin
          d = q_exp[0] - now;
          r.wait_ms = d[31] ? 31'd0 : d[30:0];
          r.status = ST_OK;
        end
      end
      default: ;
    endcase
    r.pending = q_cnt[8:0];
    return r;
  endfunction

  // sends one request and records its expected result; tvalid drops only for idles
  task automatic send_request(logic [2:0] op, logic [31:0] now, logic [23:0] iv,
                              logic [30:0] id, bit keep);
    if (!quiet && $urandom_range(99) < 19) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
      while (!quiet && $urandom_range(99) < 19) @(posedge clk_i);
    end
    s_axis_tdata  <= {5'b0, keep, id, iv, now, op};
    s_axis_tvalid <= 1'b1;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    expected_q.push_back(apply_request(op, now, iv, id, keep));
    op_hits[op]++;
    sent++;
  endtask

  // result side
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (m_axis_tvalid && m_axis_tready) begin
        result_t got, exp_r;
        got = m_axis_tdata[72:0];
        results_seen++;
        if (expected_q.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("unexpected result %h", got);
        end else begin
          exp_r = expected_q.pop_front();
          if (got !== exp_r) begin
            mismatches++;
            if (mismatches <= 10)
              $display("result %0d: expected st=%0d id=%0d wait=%0d pend=%0d, got st=%0d id=%0d wait=%0d pend=%0d",
                       results_seen, exp_r.status, exp_r.rid, exp_r.wait_ms, exp_r.pending,
                       got.status, got.rid, got.wait_ms, got.pending);
          end
        end
      end
      m_axis_tready <= !hold_off && (quiet || $urandom_range(99) >= 19);
    end
  end

  task automatic drain();
    s_axis_tvalid <= 1'b0;
    while (expected_q.size() != 0) @(posedge clk_i);
    repeat (40) @(posedge clk_i);
  endtask

  task automatic advance(int unsigned ms);
    clock_ms = clock_ms + ms;
  endtask

  task automatic test_directed();
    send_request(OP_RUN, clock_ms, 24'd0, 31'd0, 1'b0);          // run on empty
    send_request(OP_WAIT, clock_ms, 24'd0, 31'd0, 1'b0);         // wait on empty
    send_request(OP_FINISH, clock_ms, 24'd0, 31'd0, 1'b1);       // finish, nothing fired
    send_request(OP_ADD, clock_ms, 24'd0, 31'd0, 1'b0);          // zero interval
    send_request(OP_ADD, clock_ms, 24'hFFFFFF, 31'h7FFFFFFF, 1'b1);
    send_request(OP_ADD, clock_ms, 24'd5, 31'd0, 1'b0);
    send_request(OP_ADD, clock_ms, 24'd5, 31'd0, 1'b0);          // equal expiry
    send_request(OP_WAIT, clock_ms, 24'd0, 31'd0, 1'b0);
    send_request(OP_RUN, clock_ms, 24'd0, 31'd0, 1'b0);          // not due
    advance(5);
    send_request(OP_RUN, clock_ms, 24'd0, 31'd0, 1'b0);
    send_request(OP_RUN, clock_ms, 24'd0, 31'd0, 1'b0);          // fired still open
    send_request(OP_DELETE, clock_ms, 24'd0, 31'd2, 1'b0);       // fired id not queued
    send_request(OP_FINISH, clock_ms, 24'd0, 31'd0, 1'b1);
    send_request(OP_DELETE, clock_ms, 24'd0, 31'd3, 1'b0);
    send_request(OP_DELETE, clock_ms, 24'd0, 31'd99, 1'b0);
    for (int op = 5; op < 8; op++)
      send_request(op[2:0], 32'hFFFFFFFF, 24'hFFFFFF, 31'h7FFFFFFF, 1'b1);
    send_request(OP_WAIT, 32'h0, 24'd0, 31'd0, 1'b0);
    // fill past the top
    for (int i = 0; i < Depth; i++)
      send_request(OP_ADD, clock_ms, 24'(1 + (i % 3)), 31'd0, 1'b0);
    drain();
  endtask

  task automatic test_full_rearm();
    advance(10);
    send_request(OP_RUN, clock_ms, 24'd0, 31'd0, 1'b0);
    send_request(OP_ADD, clock_ms, 24'd7, 31'd0, 1'b0);
    send_request(OP_FINISH, clock_ms, 24'd0, 31'd0, 1'b1);       // re-arm into full queue
    while (q_cnt > 0) begin
      send_request(OP_DELETE, clock_ms, 24'd0, q_id[0], 1'b0);
    end
    drain();
  endtask

  task automatic test_backpressure();
    hold_off = 1'b1;
    fork
      for (int i = 0; i < 8; i++) send_request(OP_ADD, clock_ms, 24'(i + 1), 31'd0, 1'b0);
      begin
        for (int c = 0; c < 300; c++) @(posedge clk_i);
        hold_off = 1'b0;
      end
    join
    drain();
  endtask

  task automatic test_random(int n);
    logic [2:0]  op;
    logic [23:0] iv;
    logic [30:0] id;
    for (int i = 0; i < n; i++) begin
      quiet = (i >= n / 3 && i < n / 2);
      if ($urandom_range(9) < 3) advance($urandom_range(40));
      if ($urandom_range(99) == 0) advance($urandom);  // occasional wrap
      case ($urandom_range(9))
        0, 1, 2: op = OP_ADD;
        3:       op = OP_DELETE;
        4, 5:    op = OP_RUN;
        6, 7:    op = OP_FINISH;
        8:       op = OP_WAIT;
        default: op = 3'($urandom_range(7));
      endcase
      iv = ($urandom_range(19) == 0) ? 24'($urandom) : 24'($urandom_range(50));
      if (q_cnt > 0 && $urandom_range(3) != 0) id = q_id[$urandom_range(q_cnt - 1)];
      else id = 31'($urandom);
      send_request(op, ($urandom_range(29) == 0) ? $urandom : clock_ms, iv, id,
                   1'($urandom));
    end
    quiet = 1'b0;
    drain();
  endtask

  task automatic test_id_wrap();
    // each add followed by a delete of the id it was given
    for (int i = 0; i < 3; i++) begin
      send_request(OP_ADD, clock_ms, 24'd1, 31'd0, 1'b0);
      send_request(OP_DELETE, clock_ms, 24'd0, nxt_id - 31'd1, 1'b0);
    end
    drain();
  endtask

  initial begin
    nxt_id = 31'd1;
    q_cnt = 0;
    fired_v = 1'b0;
    fired_id = '0;
    fired_iv = '0;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed();
    test_full_rearm();
    test_backpressure();
    test_random(480);
    test_id_wrap();
    $display("Sent %0d requests (add %0d, delete %0d, run %0d, finish %0d, wait %0d),",
             sent, op_hits[0], op_hits[1], op_hits[2], op_hits[3], op_hits[4]);
    $display("checked %0d results incl. full queue, wrap and long output stall.",
             results_seen);
    if (mismatches == 0 && expected_q.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

  initial begin
    #5ms;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule

// ===== sim.f =====
sv/teq_pkg.sv
sv/teq_ctrl.sv
sv/teq_datapath.sv
sv/timer_event_queue.sv
verif/timer_event_queue_tb.sv
